// File: src/isaa_pkg.sv
// Package with the shared types and constants of the scatter-add accumulator.
package isaa_pkg;

   localparam int VAL_W = 32;
   localparam int CH_W  = 6;
   localparam int PT_W  = 10;
   localparam int PTS_W = 11;
   localparam int CHS_W = 7;
   localparam int CSR_W = 11;

   localparam logic [PTS_W-1:0] PTS_RESET = 11'd1024;
   localparam logic [CHS_W-1:0] CHS_RESET = 7'd64;

   // Configuration register indexes.
   localparam logic REG_POINTS   = 1'b0;
   localparam logic REG_CHANNELS = 1'b1;

   typedef enum logic [0:0] {
      OP_ACCUMULATE  = 1'b0,
      OP_READ_CLEAR  = 1'b1
   } isaa_op_type;

   // Control that travels with an item from the accept stage to the update stage.
   typedef struct packed {
      isaa_op_type op;
      logic        bad;
   } isaa_ctl_type;

   // One result transaction.
   typedef struct packed {
      logic             saturated;
      logic             bad_address;
      logic [VAL_W-1:0] read_value;
   } isaa_rsp_type;

endpackage

// File: src/isaa_store.sv
// Accumulator memory with a registered read port and the clearing sweep after reset.
module isaa_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [isaa_pkg::VAL_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [isaa_pkg::VAL_W-1:0] wr_data,
   output logic                      clr_busy
);
   import isaa_pkg::*;

   logic [VAL_W-1:0] mem_ff [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             clr_busy_ff, clr_busy_in;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [VAL_W-1:0] mem_wdata;

   // The sweep owns the write port until every entry has been zeroed.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   assign mem_we    = clr_busy_ff | wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// File: src/isaa_alu.sv
// Update logic: saturating add for accumulates, read-and-clear, rejected addresses.
module isaa_alu (
   input  isaa_pkg::isaa_ctl_type      ctl,
   input  logic [isaa_pkg::VAL_W-1:0]  old_value,
   input  logic [isaa_pkg::VAL_W-1:0]  grad_value,
   output isaa_pkg::isaa_rsp_type      rsp,
   output logic                        wr_en,
   output logic [isaa_pkg::VAL_W-1:0]  wr_data
);
   import isaa_pkg::*;

   localparam logic [VAL_W-1:0] POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

   logic [VAL_W:0]   sum;
   logic [VAL_W-1:0] sat_sum;
   logic             over_hi;
   logic             over_lo;

   // Sign-extended add; the top two bits disagree exactly on overflow.
   assign sum     = {old_value[VAL_W-1], old_value} + {grad_value[VAL_W-1], grad_value};
   assign over_hi = (sum[VAL_W:VAL_W-1] == 2'b01);
   assign over_lo = (sum[VAL_W:VAL_W-1] == 2'b10);

   always_comb begin
      if (over_hi) begin
         sat_sum = POS_LIMIT;
      end else if (over_lo) begin
         sat_sum = NEG_LIMIT;
      end else begin
         sat_sum = sum[VAL_W-1:0];
      end
   end

   always_comb begin
      rsp         = '0;
      wr_en       = 1'b0;
      wr_data     = '0;
      if (ctl.bad) begin
         rsp.bad_address = 1'b1;
      end else begin
         case (ctl.op)
            OP_ACCUMULATE: begin
               rsp.read_value = sat_sum;
               rsp.saturated  = over_hi | over_lo;
               wr_en          = 1'b1;
               wr_data        = sat_sum;
            end
            OP_READ_CLEAR: begin
               rsp.read_value = old_value;
               wr_en          = 1'b1;
            end
            default: begin
               rsp = '0;
            end
         endcase
      end
   end

endmodule

// File: src/indexed_scatter_add_accumulator_top.sv
// Top level of the scatter-add accumulator: handshakes, address check, forwarding, result register.
//
//  Channel   Direction  Ports                               Contents
//  request   in         req_tvalid/tready/tdata/tuser       channel, point, gradient; op
//  response  out        rsp_tvalid/tready/tdata/tuser       value; bad address, saturated
//  csr       in         csr_we/csr_index/csr_wdata          points_in_use, channels_in_use
//
// The edge that accepts a transaction also registers its memory read. When the update
// stage advances, it writes the updated entry back and loads the response register,
// from which the response is offered.
// The pipeline accepts one transaction per cycle while neither the sweep nor a stalled
// response holds it; the single memory write port, written at most once per transaction,
// sets that figure. After reset all MAX_CHANNELS * MAX_POINTS entries of the store
// (65536 at the defaults) are swept to zero; no request is taken during the sweep.
// A stalled response holds the update stage, which in turn holds the request side.
module indexed_scatter_add_accumulator_top #(
   parameter int MAX_POINTS   = 1024,
   parameter int MAX_CHANNELS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [47:0]                 req_tdata,  // channel[5:0], point_index[15:6], grad_value[47:16]
   input  logic [0:0]                  req_tuser,  // op[0]
   // Response channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,  // read_value[31:0]
   output logic [1:0]                  rsp_tuser,  // bad_address[0], saturated[1]
   // Configuration write port.
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [isaa_pkg::CSR_W-1:0]  csr_wdata
);
   import isaa_pkg::*;

   localparam int DEPTH = MAX_CHANNELS * MAX_POINTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Configuration registers.
   logic [PTS_W-1:0] pts_ff;
   logic [CHS_W-1:0] chs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= PTS_RESET;
         chs_ff <= CHS_RESET;
      end else if (csr_we) begin
         case (csr_index[0])
            REG_POINTS:   pts_ff <= csr_wdata[PTS_W-1:0];
            REG_CHANNELS: chs_ff <= csr_wdata[CHS_W-1:0];
            default:      pts_ff <= pts_ff;
         endcase
      end
   end

   // Request fields.
   logic [CH_W-1:0]  req_channel;
   logic [PT_W-1:0]  req_point;
   logic [VAL_W-1:0] req_grad;
   isaa_op_type      req_op;

   assign req_channel = req_tdata[CH_W-1:0];
   assign req_point   = req_tdata[CH_W+PT_W-1:CH_W];
   assign req_grad    = req_tdata[CH_W+PT_W+VAL_W-1:CH_W+PT_W];
   assign req_op      = isaa_op_type'(req_tuser[0]);

   // Address check and entry address. The multiply is by a constant.
   logic          req_bad;
   logic [31:0]   addr_wide;
   logic [AW-1:0] req_addr;

   assign req_bad = ({1'b0, req_channel} >= chs_ff) ||
                    ({1'b0, req_point} >= pts_ff) ||
                    (32'(req_channel) >= 32'(MAX_CHANNELS)) ||
                    (32'(req_point) >= 32'(MAX_POINTS));
   assign addr_wide = 32'(req_channel) * 32'(MAX_POINTS) + 32'(req_point);
   assign req_addr  = addr_wide[AW-1:0];

   // Pipeline control.
   logic clr_busy;
   logic req_accept;
   logic s1_adv;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign s1_adv     = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~clr_busy & (~s1_valid_ff | s1_adv);
   assign req_accept = req_tvalid & req_tready;

   // Update stage registers; the memory read data arrives with them.
   isaa_ctl_type     s1_ctl_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic [VAL_W-1:0] s1_grad_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ctl_ff.op  <= req_op;
         s1_ctl_ff.bad <= req_bad;
         s1_addr_ff    <= req_addr;
         s1_grad_ff    <= req_grad;
      end
   end

   // Memory.
   logic [VAL_W-1:0] rd_data;
   logic             alu_we;
   logic [VAL_W-1:0] alu_wdata;
   logic             mem_we;

   assign mem_we = s1_adv & alu_we;

   isaa_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_addr),
      .rd_data  (rd_data),
      .wr_en    (mem_we),
      .wr_addr  (s1_addr_ff),
      .wr_data  (alu_wdata),
      .clr_busy (clr_busy)
   );

   // Forwarding: the most recent write is kept, and when the entry in the update
   // stage matches it, its value replaces the read data, which may predate that
   // write. The register always holds the entry's latest value, so a match is safe.
   logic             fwd_valid_ff;
   logic [AW-1:0]    fwd_addr_ff;
   logic [VAL_W-1:0] fwd_data_ff;
   logic             fwd_hit;
   logic [VAL_W-1:0] old_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (mem_we) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= alu_wdata;
      end
   end

   assign fwd_hit   = fwd_valid_ff && (fwd_addr_ff == s1_addr_ff);
   assign old_value = fwd_hit ? fwd_data_ff : rd_data;

   isaa_rsp_type alu_rsp;

   isaa_alu u_alu (
      .ctl        (s1_ctl_ff),
      .old_value  (old_value),
      .grad_value (s1_grad_ff),
      .rsp        (alu_rsp),
      .wr_en      (alu_we),
      .wr_data    (alu_wdata)
   );

   // Response register.
   isaa_rsp_type rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= alu_rsp;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff.read_value;
   assign rsp_tuser[0] = rsp_ff.bad_address;
   assign rsp_tuser[1] = rsp_ff.saturated;

`ifndef SYNTH
   // No request may enter while the sweep still owns the memory.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_tready)
      else $error("request taken during clearing sweep");

   // An accepted transaction is in the update stage on the next cycle.
   a_accept_reaches_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction lost before update stage");

   // A rejected address never writes the store.
   a_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ctl_ff.bad) |-> !alu_we)
      else $error("rejected address wrote the store");

   // A rejected address answers zero and is never flagged as saturated.
   a_bad_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.bad_address) |-> (rsp_ff.read_value == '0 && !rsp_ff.saturated))
      else $error("rejected address response not clean");
`endif

endmodule

// File: verif/tb_indexed_scatter_add_accumulator_top.sv
// Self-checking testbench for the scatter-add accumulator: directed table, random phases, scoreboard.
module tb_indexed_scatter_add_accumulator_top;
   import isaa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PT = 1024;
   localparam int MAX_CH = 64;

   // The clearing sweep after reset covers all MAX_CH * MAX_PT entries with nothing accepted.
   // Every other quiet stretch is short, so the limit lies well beyond the sweep.
   localparam int STALL_LIMIT_CYCLES = 4 * MAX_CH * MAX_PT;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 106;

   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   // Kinds of row in the directed table. A predicted row is checked against the
   // mirror of the store; a known row carries its expected result in the table.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_KNOWN,
      ROW_SET_POINTS,
      ROW_SET_CHANNELS
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      isaa_op_type      op;
      logic [CH_W-1:0]  ch;
      logic [PT_W-1:0]  pt;
      logic [VAL_W-1:0] arg;        // Gradient, or the register value for a set row.
      logic [VAL_W-1:0] exp_value;
      logic             exp_bad;
      logic             exp_sat;
   } plan_row_type;

   localparam int PLAN_LEN = 34;

   // Directed table. It starts from the reset configuration of 1024 points and 64 channels.
   plan_row_type directed_plan [PLAN_LEN] = '{
      // Reads of the corner entries right after the clearing sweep return zero.
      '{ROW_KNOWN,   OP_READ_CLEAR, 6'd0,  10'd0,    32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_READ_CLEAR, 6'd63, 10'd1023, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      // Fill to the positive limit, then push past it.
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd0,  10'd0,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd0,  10'd0,    32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b1},
      '{ROW_KNOWN,   OP_READ_CLEAR, 6'd0,  10'd0,    32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_READ_CLEAR, 6'd0,  10'd0,    32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
      // Same on the negative side at the far corner; the read carries a gradient it must ignore.
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd63, 10'd1023, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd63, 10'd1023, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b1},
      '{ROW_KNOWN,   OP_READ_CLEAR, 6'd63, 10'd1023, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
      // Back-to-back updates of one entry exercise the forwarding path.
      '{ROW_PREDICT, OP_ACCUMULATE, 6'd5,  10'd7,    32'h1234_5678, 32'h0, 1'b0, 1'b0},
      '{ROW_PREDICT, OP_ACCUMULATE, 6'd5,  10'd7,    32'hEDCB_A988, 32'h0, 1'b0, 1'b0},
      '{ROW_PREDICT, OP_ACCUMULATE, 6'd42, 10'd555,  32'hFFFF_0000, 32'h0, 1'b0, 1'b0},
      '{ROW_PREDICT, OP_READ_CLEAR, 6'd42, 10'd555,  32'h0000_0000, 32'h0, 1'b0, 1'b0},
      // Narrow the address space: the first address past each count is rejected.
      '{ROW_SET_POINTS,   OP_ACCUMULATE, 6'd0, 10'd0, 32'd10, 32'h0, 1'b0, 1'b0},
      '{ROW_SET_CHANNELS, OP_ACCUMULATE, 6'd0, 10'd0, 32'd3,  32'h0, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd3,  10'd0,    32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0},
      '{ROW_KNOWN,   OP_READ_CLEAR, 6'd0,  10'd10,   32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
      '{ROW_PREDICT, OP_ACCUMULATE, 6'd2,  10'd9,    32'h0001_0000, 32'h0, 1'b0, 1'b0},
      '{ROW_PREDICT, OP_READ_CLEAR, 6'd2,  10'd9,    32'h0000_0000, 32'h0, 1'b0, 1'b0},
      // A point count of zero rejects every address.
      '{ROW_SET_POINTS,   OP_ACCUMULATE, 6'd0, 10'd0, 32'd0, 32'h0, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_READ_CLEAR, 6'd0,  10'd0,    32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
      // Counts above their range are taken as written; the store bounds still hold.
      '{ROW_SET_POINTS,   OP_ACCUMULATE, 6'd0, 10'd0, 32'd2047, 32'h0, 1'b0, 1'b0},
      '{ROW_SET_CHANNELS, OP_ACCUMULATE, 6'd0, 10'd0, 32'd127,  32'h0, 1'b0, 1'b0},
      '{ROW_PREDICT, OP_ACCUMULATE, 6'd63, 10'd1023, 32'h0000_0005, 32'h0, 1'b0, 1'b0},
      '{ROW_PREDICT, OP_READ_CLEAR, 6'd63, 10'd1023, 32'h0000_0000, 32'h0, 1'b0, 1'b0},
      // Smallest legal configuration: a single entry is addressable.
      '{ROW_SET_POINTS,   OP_ACCUMULATE, 6'd0, 10'd0, 32'd1, 32'h0, 1'b0, 1'b0},
      '{ROW_SET_CHANNELS, OP_ACCUMULATE, 6'd0, 10'd0, 32'd1, 32'h0, 1'b0, 1'b0},
      '{ROW_PREDICT, OP_ACCUMULATE, 6'd0,  10'd0,    32'hFFFF_FFFD, 32'h0, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd1,  10'd0,    32'h0000_0007, 32'h0000_0000, 1'b1, 1'b0},
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd0,  10'd1,    32'h0000_0007, 32'h0000_0000, 1'b1, 1'b0},
      // A channel count of zero rejects every address as well.
      '{ROW_SET_CHANNELS, OP_ACCUMULATE, 6'd0, 10'd0, 32'd0, 32'h0, 1'b0, 1'b0},
      '{ROW_KNOWN,   OP_ACCUMULATE, 6'd0,  10'd0,    32'h0000_0007, 32'h0000_0000, 1'b1, 1'b0},
      // Back to the reset configuration for the random phases.
      '{ROW_SET_POINTS,   OP_ACCUMULATE, 6'd0, 10'd0, 32'd1024, 32'h0, 1'b0, 1'b0},
      '{ROW_SET_CHANNELS, OP_ACCUMULATE, 6'd0, 10'd0, 32'd64,   32'h0, 1'b0, 1'b0}
   };

   // Every input is known from time zero; reset is held from time zero until the stimulus releases it.
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [47:0]       req_tdata  = '0;  // channel[5:0], point_index[15:6], grad_value[47:16]
   logic [0:0]        req_tuser  = '0;  // op[0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;        // read_value[31:0]
   logic [1:0]        rsp_tuser;        // bad_address[0], saturated[1]
   logic              csr_we     = 1'b0;
   logic [0:0]        csr_index  = REG_POINTS;
   logic [CSR_W-1:0]  csr_wdata  = '0;

   // Sideband that travels with each request: a known row carries its own expectation.
   logic              known_row  = 1'b0;
   isaa_rsp_type      known_rsp  = '0;

   // Mirror of the accumulator store and of the two count registers.
   logic [VAL_W-1:0]  gradient_sums [MAX_CH*MAX_PT] = '{default: '0};
   logic [PTS_W-1:0]  pts_cfg = PTS_RESET;
   logic [CHS_W-1:0]  chs_cfg = CHS_RESET;

   // Results still owed by the block, oldest first.
   isaa_rsp_type      owed_results [$];

   int                failure_count = 0;
   int                quiet_cycles  = 0;
   int                burst_left    = 0;
   int                ready_mode    = 0;
   int                ready_left    = 0;

   indexed_scatter_add_accumulator_top #(
      .MAX_POINTS   (MAX_PT),
      .MAX_CHANNELS (MAX_CH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Works out the result of one accepted transaction and applies it to the mirror.
   // Rejected addresses leave the store alone; reads return the old value and clear it;
   // accumulates clamp the exact sum to the signed 32-bit range.
   function automatic isaa_rsp_type scatter_add_predict(isaa_op_type op, logic [CH_W-1:0] ch,
         logic [PT_W-1:0] pt, logic [VAL_W-1:0] grad);
      isaa_rsp_type rsp;
      int unsigned  slot;
      longint       sum;
      rsp = '0;
      if (ch >= chs_cfg || pt >= pts_cfg || int'(ch) >= MAX_CH || int'(pt) >= MAX_PT) begin
         rsp.bad_address = 1'b1;
         return rsp;
      end
      slot = int'(ch) * MAX_PT + int'(pt);
      if (op == OP_READ_CLEAR) begin
         rsp.read_value = gradient_sums[slot];
         gradient_sums[slot] = '0;
         return rsp;
      end
      sum = longint'($signed(gradient_sums[slot])) + longint'($signed(grad));
      if (sum > SUM_MAX) begin
         sum = SUM_MAX;
         rsp.saturated = 1'b1;
      end else if (sum < SUM_MIN) begin
         sum = SUM_MIN;
         rsp.saturated = 1'b1;
      end
      gradient_sums[slot] = 32'(sum);
      rsp.read_value = gradient_sums[slot];
      return rsp;
   endfunction

   function automatic void compare_field(string field, logic [VAL_W-1:0] want,
         logic [VAL_W-1:0] got);
      if (want !== got) begin
         failure_count++;
         if (failure_count <= 10)
            $display("mismatch on %s at %0t: expected %h, actual %h", field, $realtime, want, got);
      end
   endfunction

   // Lowers the request valid and waits until every owed result has come back.
   // The loop always passes at least one edge, so the scoreboard has seen any
   // transaction accepted at the current edge before the queue is looked at.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      do
         @(posedge clock);
      while (owed_results.size() != 0);
   endtask

   // Count registers change only while the block holds no transaction.
   task automatic set_register(logic [0:0] index, logic [CSR_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == REG_POINTS)
         pts_cfg = value[PTS_W-1:0];
      else
         chs_cfg = value[CHS_W-1:0];
   endtask

   // Presents one request and returns at the edge where it is accepted. The sender
   // works in bursts; between bursts valid drops for a random gap.
   task automatic send_item(logic known, isaa_rsp_type want, isaa_op_type op,
         logic [CH_W-1:0] ch, logic [PT_W-1:0] pt, logic [VAL_W-1:0] grad);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 24);
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      csr_we     <= 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= {grad, pt, ch};
      req_tuser  <= op;
      known_row  <= known;
      known_rsp  <= want;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // Random traffic: mostly a small hot set of entries so that sums build up,
   // saturate and get drained, with the rest spread over the whole address space.
   task automatic send_random_item();
      isaa_op_type      op;
      logic [CH_W-1:0]  ch;
      logic [PT_W-1:0]  pt;
      logic [VAL_W-1:0] grad;
      op = ($urandom_range(0, 3) == 0) ? OP_READ_CLEAR : OP_ACCUMULATE;
      if ($urandom_range(0, 9) < 7) begin
         ch = CH_W'($urandom_range(0, 3));
         pt = PT_W'($urandom_range(0, 7));
      end else begin
         ch = CH_W'($urandom);
         pt = PT_W'($urandom);
      end
      case ($urandom_range(0, 3))
         0:       grad = $urandom;
         1:       grad = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
         2:       grad = 32'h7FFF_FFFF - 32'($urandom_range(0, 255));
         default: grad = 32'h8000_0000 + 32'($urandom_range(0, 255));
      endcase
      send_item(1'b0, '0, op, ch, pt, grad);
   endtask

   // The receiver switches between always ready, mostly ready and mostly stalled,
   // each for a random stretch.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= $urandom_range(20, 200);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 9) < 7);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Scoreboard. Responses are checked before requests are predicted, so a response
   // that arrives with nothing owed is caught even if a request lands at the same edge.
   // The same block runs the watchdog on cycles in which no transaction moves.
   always @(posedge clock) begin : scoreboard
      isaa_rsp_type seen;
      isaa_rsp_type want;
      logic         moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            seen.read_value  = rsp_tdata;
            seen.bad_address = rsp_tuser[0];
            seen.saturated   = rsp_tuser[1];
            if (owed_results.size() == 0) begin
               failure_count++;
               if (failure_count <= 10)
                  $display("response with no transaction owed at %0t: value %h, flags %b",
                           $realtime, rsp_tdata, rsp_tuser);
            end else begin
               want = owed_results.pop_front();
               compare_field("read_value", want.read_value, seen.read_value);
               compare_field("bad_address", 32'(want.bad_address), 32'(seen.bad_address));
               compare_field("saturated", 32'(want.saturated), 32'(seen.saturated));
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            // The mirror is always updated; a known row only replaces what is expected.
            want = scatter_add_predict(isaa_op_type'(req_tuser[0]), req_tdata[5:0],
                                       req_tdata[15:6], req_tdata[47:16]);
            owed_results.push_back(known_row ? known_rsp : want);
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus: reset, the directed table, then random phases, each under its own
   // count settings (reset values, random legal values, anything the register
   // widths allow, and very small counts).
   initial begin
      int               phase;
      int               n;
      plan_row_type     row;
      logic [CSR_W-1:0] pts_value;
      logic [CSR_W-1:0] chs_value;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         case (row.kind)
            ROW_SET_POINTS:   set_register(REG_POINTS, row.arg[CSR_W-1:0]);
            ROW_SET_CHANNELS: set_register(REG_CHANNELS, row.arg[CSR_W-1:0]);
            default: begin
               send_item(row.kind == ROW_KNOWN,
                         '{saturated: row.exp_sat, bad_address: row.exp_bad,
                           read_value: row.exp_value},
                         row.op, row.ch, row.pt, row.arg);
            end
         endcase
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin
               pts_value = CSR_W'(PTS_RESET);
               chs_value = CSR_W'(CHS_RESET);
            end
            1: begin
               pts_value = CSR_W'($urandom_range(1, MAX_PT));
               chs_value = CSR_W'($urandom_range(1, MAX_CH));
            end
            2: begin
               pts_value = CSR_W'($urandom_range(0, 2047));
               chs_value = CSR_W'($urandom_range(0, 127));
            end
            default: begin
               pts_value = CSR_W'($urandom_range(1, 8));
               chs_value = CSR_W'($urandom_range(1, 4));
            end
         endcase
         set_register(REG_POINTS, pts_value);
         set_register(REG_CHANNELS, chs_value);
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            send_random_item();
      end

      // Drain, then keep the clock running so that any stray response still shows.
      wait_idle();
      repeat (4) @(posedge clock);
      if (failure_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
